// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition checked at every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wtme_pkg.sv
package wtme_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_POST   = 2'd0,
    OP_ARRIVE = 2'd1,
    OP_PROBE  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_QUEUED      = 3'd0,
    ST_MATCHED     = 3'd1,
    ST_FULL        = 3'd2,
    ST_PROBE_HIT   = 3'd3,
    ST_PROBE_MISS  = 3'd4,
    ST_LOOKUP_HIT  = 3'd5,
    ST_LOOKUP_MISS = 3'd6,
    ST_MATCH_DROP  = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] source;
    logic        any_source;
    logic [31:0] tag;
    logic        any_tag;
    logic        silent;
    logic [31:0] offset;
    logic [31:0] length;
    logic [63:0] buffer_addr;
    logic [31:0] buffer_key;
    logic [15:0] handle;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] read_src_addr;
    logic [31:0] remote_key;
    logic [63:0] read_dst_addr;
    logic [31:0] read_length;
    logic [31:0] local_key;
    logic [15:0] remote_handle;
    logic [15:0] local_handle;
    logic [15:0] found_source;
    logic        found_any_source;
  } out_item_t;

  // One queue entry; silent and offset are unused in the arrival queue.
  typedef struct packed {
    logic [15:0] source;
    logic        any_source;
    logic [31:0] tag;
    logic        any_tag;
    logic        silent;
    logic [31:0] offset;
    logic [63:0] addr;
    logic [31:0] key;
    logic [31:0] length;
    logic [15:0] handle;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic clr_scan;   // reset the scan index
    logic step;       // read the next entry and advance
    logic shift;      // move one entry down during compaction
    logic push;       // append the item to a queue
    logic push_arr;   // 1 selects the arrival queue
    logic dec_arr;    // finish a removal from arrivals
    logic dec_post;   // finish a removal from posted
    logic set_out;    // build the result register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] opcode;
    logic       scan_done;  // index reached the count of the scanned queue
    logic       hit;        // entry under test matches
    logic       shift_done; // compaction reached the tail
    logic       arr_full;
    logic       post_full;
    logic       silent;
    logic       hit_silent; // matched posted entry was silent
  } sts_t;

  function automatic logic keys_match(input logic [15:0] s_a, input logic as_a,
                                      input logic [31:0] t_a, input logic at_a,
                                      input logic [15:0] s_b, input logic as_b,
                                      input logic [31:0] t_b, input logic at_b);
    logic s_ok;
    logic t_ok;
    s_ok = as_a | as_b | (s_a == s_b);
    t_ok = at_a | at_b | (t_a == t_b);
    return s_ok & t_ok;
  endfunction

  function automatic logic [63:0] add_offset(input logic [63:0] addr,
                                             input logic [31:0] off);
    if (off != 32'd0 && !off[31]) begin
      return addr + {32'd0, off};
    end
    return addr;
  endfunction

endpackage

// File: rtl/core/wtme_stream_if.sv
interface wtme_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/wtme_datapath.sv
module wtme_datapath #(
  parameter int unsigned QUEUE_DEPTH = wtme_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wtme_pkg::in_item_t  in_item,
  input  wtme_pkg::cmd_t      cmd,
  input  wtme_pkg::status_t   out_status,
  output wtme_pkg::sts_t      sts,
  output wtme_pkg::out_item_t out_item
);
  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  wtme_pkg::entry_t arr_mem [QUEUE_DEPTH];
  wtme_pkg::entry_t post_mem [QUEUE_DEPTH];

  wtme_pkg::in_item_t  item_r;
  wtme_pkg::entry_t    ent_r;      // entry read at idx
  wtme_pkg::entry_t    hit_r;      // saved matched entry
  wtme_pkg::out_item_t out_r;
  wtme_pkg::out_item_t out_nxt;
  logic [CW-1:0] arr_cnt_r, post_cnt_r, idx_r;
  logic          ent_vld_r;
  logic          use_post;
  logic          hit_now;
  logic [CW-1:0] cnt_sel;

  assign use_post = (item_r.opcode == wtme_pkg::OP_ARRIVE);
  assign cnt_sel  = use_post ? post_cnt_r : arr_cnt_r;

  always_comb begin
    if (item_r.opcode == wtme_pkg::OP_LOOKUP) begin
      hit_now = (ent_r.any_tag == item_r.any_tag) &&
                (item_r.any_tag || ent_r.tag == item_r.tag);
    end else begin
      hit_now = wtme_pkg::keys_match(ent_r.source, ent_r.any_source, ent_r.tag,
                  ent_r.any_tag, item_r.source, item_r.any_source, item_r.tag,
                  item_r.any_tag);
    end
  end

  assign sts.opcode     = item_r.opcode;
  assign sts.scan_done  = (idx_r >= cnt_sel) && !ent_vld_r;
  assign sts.hit        = ent_vld_r && hit_now;
  assign sts.shift_done = (idx_r >= cnt_sel);
  assign sts.arr_full   = (arr_cnt_r == CW'(QUEUE_DEPTH));
  assign sts.post_full  = (post_cnt_r == CW'(QUEUE_DEPTH));
  assign sts.silent     = item_r.silent;
  assign sts.hit_silent = hit_r.silent;
  assign out_item       = out_r;

  always_comb begin
    out_nxt        = '0;
    out_nxt.status = out_status;
    if (out_status == wtme_pkg::ST_MATCHED || out_status == wtme_pkg::ST_MATCH_DROP) begin
      if (use_post) begin
        out_nxt.read_src_addr = hit_r.silent ?
                                wtme_pkg::add_offset(item_r.buffer_addr, hit_r.offset) :
                                item_r.buffer_addr;
        out_nxt.remote_key    = item_r.buffer_key;
        out_nxt.read_dst_addr = hit_r.addr;
        out_nxt.read_length   = hit_r.silent ? hit_r.length : item_r.length;
        out_nxt.local_key     = hit_r.key;
        out_nxt.remote_handle = item_r.handle;
        out_nxt.local_handle  = hit_r.handle;
      end else begin
        out_nxt.read_src_addr = item_r.silent ?
                                wtme_pkg::add_offset(hit_r.addr, item_r.offset) :
                                hit_r.addr;
        out_nxt.remote_key    = hit_r.key;
        out_nxt.read_dst_addr = item_r.buffer_addr;
        out_nxt.read_length   = item_r.silent ? item_r.length : hit_r.length;
        out_nxt.local_key     = item_r.buffer_key;
        out_nxt.remote_handle = hit_r.handle;
        out_nxt.local_handle  = item_r.handle;
      end
    end
    if (out_status == wtme_pkg::ST_LOOKUP_HIT) begin
      out_nxt.found_source     = hit_r.source;
      out_nxt.found_any_source = hit_r.any_source;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arr_cnt_r  <= '0;
      post_cnt_r <= '0;
      idx_r      <= '0;
      ent_vld_r  <= 1'b0;
    end else begin
      ent_vld_r <= cmd.step;
      if (cmd.clr_scan) begin
        idx_r <= '0;
      end
      if (cmd.step || cmd.shift) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.dec_arr) begin
        arr_cnt_r <= arr_cnt_r - CW'(1);
      end
      if (cmd.dec_post) begin
        post_cnt_r <= post_cnt_r - CW'(1);
      end
      if (cmd.push) begin
        if (cmd.push_arr) begin
          arr_cnt_r <= (cmd.dec_arr ? arr_cnt_r - CW'(1) : arr_cnt_r) + CW'(1);
        end else begin
          post_cnt_r <= post_cnt_r + CW'(1);
        end
      end
    end
  end

  // Memories: one read and one write per cycle each.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.step) begin
      ent_r <= use_post ? post_mem[idx_r[IW-1:0]] : arr_mem[idx_r[IW-1:0]];
    end
    if (sts.hit) begin
      hit_r <= ent_r;
    end
    if (cmd.shift) begin
      // Compaction writes entry idx-1 from entry idx (hit was at idx-1).
      if (use_post) begin
        post_mem[IW'(idx_r - CW'(1))] <= post_mem[idx_r[IW-1:0]];
      end else begin
        arr_mem[IW'(idx_r - CW'(1))] <= arr_mem[idx_r[IW-1:0]];
      end
    end
    if (cmd.push) begin
      if (cmd.push_arr) begin
        arr_mem[IW'(cmd.dec_arr ? arr_cnt_r - CW'(1) : arr_cnt_r)] <= '{
          source: item_r.source, any_source: item_r.any_source, tag: item_r.tag,
          any_tag: item_r.any_tag, silent: 1'b0, offset: '0,
          addr: item_r.buffer_addr, key: item_r.buffer_key,
          length: item_r.length, handle: item_r.handle};
      end else begin
        post_mem[IW'(post_cnt_r)] <= '{
          source: item_r.source, any_source: item_r.any_source, tag: item_r.tag,
          any_tag: item_r.any_tag, silent: item_r.silent, offset: item_r.offset,
          addr: item_r.buffer_addr, key: item_r.buffer_key,
          length: item_r.length, handle: item_r.handle};
      end
    end
    if (cmd.set_out) begin
      out_r <= out_nxt;
    end
  end
endmodule

// File: rtl/core/wtme_ctrl.sv
module wtme_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wtme_pkg::sts_t     sts,
  output wtme_pkg::cmd_t     cmd,
  output wtme_pkg::status_t  out_status
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_TEST, S_SHIFT, S_FINISH, S_OUT} state_t;

  state_t            state_r;
  logic              out_valid_r;
  wtme_pkg::status_t status_r;
  logic              hit_r;

  assign in_ready   = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid  = out_valid_r;
  assign out_status = status_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load     = in_valid && in_ready;
        cmd.clr_scan = in_valid && in_ready;
      end
      S_SCAN: begin
        cmd.step = !sts.scan_done;
      end
      S_SHIFT: begin
        cmd.shift = !sts.shift_done;
        if (sts.shift_done) begin
          cmd.dec_arr  = (sts.opcode != wtme_pkg::OP_ARRIVE);
          cmd.dec_post = (sts.opcode == wtme_pkg::OP_ARRIVE);
        end
      end
      S_FINISH: begin
        if (!hit_r && (sts.opcode == wtme_pkg::OP_POST || sts.opcode == wtme_pkg::OP_ARRIVE)) begin
          cmd.push     = (sts.opcode == wtme_pkg::OP_POST) ? !sts.post_full : !sts.arr_full;
          cmd.push_arr = (sts.opcode == wtme_pkg::OP_ARRIVE);
        end
        if (hit_r && sts.opcode == wtme_pkg::OP_ARRIVE && sts.hit_silent) begin
          cmd.push     = !sts.arr_full;
          cmd.push_arr = 1'b1;
        end
      end
      S_OUT: begin
        // The status register was settled by the finish cycle.
        cmd.set_out = 1'b1;
      end
      default: ;
    endcase
  end

  // A found entry is tested in the cycle after its read; removals then compact.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= wtme_pkg::ST_QUEUED;
      hit_r       <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (cmd.load) begin
            hit_r   <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state_r <= S_FINISH;
          end else begin
            state_r <= S_TEST;
          end
        end
        S_TEST: begin
          if (sts.hit) begin
            hit_r <= 1'b1;
            if (sts.opcode == wtme_pkg::OP_ARRIVE ||
                (sts.opcode == wtme_pkg::OP_POST && !sts.silent)) begin
              state_r <= S_SHIFT;
            end else begin
              state_r <= S_FINISH;
            end
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SHIFT: begin
          if (sts.shift_done) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          case (sts.opcode)
            wtme_pkg::OP_POST:
              status_r <= hit_r ? wtme_pkg::ST_MATCHED :
                          (sts.post_full ? wtme_pkg::ST_FULL : wtme_pkg::ST_QUEUED);
            wtme_pkg::OP_ARRIVE:
              status_r <= hit_r ? ((sts.hit_silent && sts.arr_full) ?
                                   wtme_pkg::ST_MATCH_DROP : wtme_pkg::ST_MATCHED) :
                          (sts.arr_full ? wtme_pkg::ST_FULL : wtme_pkg::ST_QUEUED);
            wtme_pkg::OP_PROBE:
              status_r <= hit_r ? wtme_pkg::ST_PROBE_HIT : wtme_pkg::ST_PROBE_MISS;
            default:
              status_r <= hit_r ? wtme_pkg::ST_LOOKUP_HIT : wtme_pkg::ST_LOOKUP_MISS;
          endcase
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/wildcard_tag_matching_engine.sv
// Each transaction searches its queue one entry at a time (up to QUEUE_DEPTH entries); then
// entries behind a removal are moved down to close the gap, and the result is registered.
// Throughput: one transaction at a time; the next input is taken the cycle after the
// result is accepted, so the serial queue scan and compaction set the rate.
// Reset: synchronous, active low; both queues become empty, entry memories
// are not cleared.
module wildcard_tag_matching_engine #(
  parameter int unsigned QUEUE_DEPTH = wtme_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  wtme_stream_if.sink   in_ch,
  wtme_stream_if.source out_ch
);
  wtme_pkg::cmd_t      cmd;
  wtme_pkg::sts_t      sts;
  wtme_pkg::status_t   out_status;
  wtme_pkg::out_item_t out_item;

  wtme_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd, .out_status
  );

  wtme_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n,
    .in_item(wtme_pkg::in_item_t'(in_ch.data)),
    .cmd, .out_status, .sts, .out_item
  );

  assign out_ch.data = out_item;
endmodule

// File: rtl/core/wtme_checker.sv
`include "assert_macros.svh"
module wtme_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] out_status
);
  `CHK_IMPL(a_no_accept_while_pending, clk, rst_n, !(in_ready && out_valid), "input taken while result pending")
  `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after accept")
  `CHK_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status), "result changed while stalled")
endmodule

bind wildcard_tag_matching_engine wtme_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.data[275:273])
);

// File: tb/sv/wildcard_tag_matching_engine_tb.sv
`timescale 1ns / 1ps

module wildcard_tag_matching_engine_tb;

  localparam int unsigned DEPTH = wtme_pkg::QUEUE_DEPTH_DEF;
  localparam int unsigned NUM_RANDOM = 900;
  localparam int unsigned CALM_TAIL = 120;

  typedef struct {
    wtme_pkg::in_item_t  item;
    bit                  typed;
    wtme_pkg::out_item_t exp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   errors;
  bit   calm;
  bit   stim_done;

  wtme_stream_if #(.W($bits(wtme_pkg::in_item_t)))  in_ch ();
  wtme_stream_if #(.W($bits(wtme_pkg::out_item_t))) out_ch ();

  wildcard_tag_matching_engine #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Shadow copies of the two queues and the descriptors still to come out.
  wtme_pkg::entry_t    arrivals[$];
  wtme_pkg::entry_t    posted[$];
  wtme_pkg::out_item_t pending_desc[$];
  stim_row_t           directed_rows[$];

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic tags_agree(wtme_pkg::entry_t a, wtme_pkg::entry_t b);
    logic src_ok;
    logic tag_ok;
    src_ok = a.any_source | b.any_source | (a.source == b.source);
    tag_ok = a.any_tag | b.any_tag | (a.tag == b.tag);
    return src_ok & tag_ok;
  endfunction

  function automatic logic [63:0] shifted_addr(logic [63:0] base, logic [31:0] off);
    return (off != 32'd0 && !off[31]) ? base + {32'd0, off} : base;
  endfunction

  // Computes the descriptor for one transaction and updates the shadow queues.
  function automatic wtme_pkg::out_item_t match_descriptor(wtme_pkg::in_item_t t);
    wtme_pkg::out_item_t r;
    wtme_pkg::entry_t    e;
    wtme_pkg::entry_t    hit_e;
    r = '0;
    e = '0;
    e.source = t.source;
    e.any_source = t.any_source;
    e.tag = t.tag;
    e.any_tag = t.any_tag;
    e.addr = t.buffer_addr;
    e.key = t.buffer_key;
    e.length = t.length;
    e.handle = t.handle;
    case (wtme_pkg::op_t'(t.opcode))
      wtme_pkg::OP_POST: begin
        e.silent = t.silent;
        e.offset = t.offset;
        foreach (arrivals[i]) begin
          if (tags_agree(arrivals[i], e)) begin
            hit_e = arrivals[i];
            r.status = wtme_pkg::ST_MATCHED;
            r.read_src_addr = t.silent ? shifted_addr(hit_e.addr, t.offset) : hit_e.addr;
            r.remote_key = hit_e.key;
            r.read_dst_addr = t.buffer_addr;
            r.read_length = t.silent ? t.length : hit_e.length;
            r.local_key = t.buffer_key;
            r.remote_handle = hit_e.handle;
            r.local_handle = t.handle;
            if (!t.silent) arrivals.delete(i);
            return r;
          end
        end
        if (posted.size() < DEPTH) begin
          posted.push_back(e);
          r.status = wtme_pkg::ST_QUEUED;
        end else begin
          r.status = wtme_pkg::ST_FULL;
        end
      end
      wtme_pkg::OP_ARRIVE: begin
        foreach (posted[i]) begin
          if (tags_agree(posted[i], e)) begin
            hit_e = posted[i];
            r.status = wtme_pkg::ST_MATCHED;
            r.read_src_addr = hit_e.silent ? shifted_addr(t.buffer_addr, hit_e.offset)
                                           : t.buffer_addr;
            r.remote_key = t.buffer_key;
            r.read_dst_addr = hit_e.addr;
            r.read_length = hit_e.silent ? hit_e.length : t.length;
            r.local_key = hit_e.key;
            r.remote_handle = t.handle;
            r.local_handle = hit_e.handle;
            posted.delete(i);
            // A silent receive leaves the arrival to be queued as well.
            if (hit_e.silent) begin
              if (arrivals.size() < DEPTH) arrivals.push_back(e);
              else r.status = wtme_pkg::ST_MATCH_DROP;
            end
            return r;
          end
        end
        if (arrivals.size() < DEPTH) begin
          arrivals.push_back(e);
          r.status = wtme_pkg::ST_QUEUED;
        end else begin
          r.status = wtme_pkg::ST_FULL;
        end
      end
      wtme_pkg::OP_PROBE: begin
        r.status = wtme_pkg::ST_PROBE_MISS;
        foreach (arrivals[i]) begin
          if (tags_agree(arrivals[i], e)) begin
            r.status = wtme_pkg::ST_PROBE_HIT;
            break;
          end
        end
      end
      default: begin
        r.status = wtme_pkg::ST_LOOKUP_MISS;
        foreach (arrivals[i]) begin
          if (arrivals[i].any_tag == t.any_tag && (t.any_tag || arrivals[i].tag == t.tag))
          begin
            r.status = wtme_pkg::ST_LOOKUP_HIT;
            r.found_source = arrivals[i].source;
            r.found_any_source = arrivals[i].any_source;
            break;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic wtme_pkg::in_item_t make_item(wtme_pkg::op_t op, logic [15:0] src,
                                                   logic anys, logic [31:0] tag,
                                                   logic anyt, logic sil,
                                                   logic [31:0] off, logic [31:0] len,
                                                   logic [63:0] addr, logic [31:0] key,
                                                   logic [15:0] hnd);
    wtme_pkg::in_item_t t;
    t.opcode = op;
    t.source = src;
    t.any_source = anys;
    t.tag = tag;
    t.any_tag = anyt;
    t.silent = sil;
    t.offset = off;
    t.length = len;
    t.buffer_addr = addr;
    t.buffer_key = key;
    t.handle = hnd;
    return t;
  endfunction

  function automatic void add_row(wtme_pkg::in_item_t t, bit typed = 1'b0,
                                  wtme_pkg::status_t st = wtme_pkg::ST_QUEUED);
    stim_row_t row;
    row.item = t;
    row.typed = typed;
    row.exp = '0;
    row.exp.status = st;
    directed_rows.push_back(row);
  endfunction

  // Small pools for sources and tags keep matches frequent; the rest is wide.
  function automatic wtme_pkg::in_item_t random_item(int unsigned phase);
    wtme_pkg::in_item_t t;
    int unsigned        pick;
    wtme_pkg::op_t      op;
    pick = $urandom_range(0, 99);
    case (phase)
      1: op = pick < 60 ? wtme_pkg::OP_POST : pick < 85 ? wtme_pkg::OP_ARRIVE :
              pick < 93 ? wtme_pkg::OP_PROBE : wtme_pkg::OP_LOOKUP;
      2: op = pick < 30 ? wtme_pkg::OP_POST : pick < 85 ? wtme_pkg::OP_ARRIVE :
              pick < 93 ? wtme_pkg::OP_PROBE : wtme_pkg::OP_LOOKUP;
      default: op = wtme_pkg::op_t'(pick % 4);
    endcase
    t.opcode = op;
    t.source = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    t.any_source = ($urandom_range(0, 5) == 0);
    t.tag = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 3));
    t.any_tag = ($urandom_range(0, 5) == 0);
    t.silent = (phase == 2) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: t.offset = 32'd0;
      1: t.offset = 32'($urandom_range(1, 4096));
      2: t.offset = 32'h8000_0000 | $urandom;
      default: t.offset = $urandom;
    endcase
    t.length = $urandom;
    t.buffer_addr = {$urandom, $urandom};
    t.buffer_key = $urandom;
    t.handle = 16'($urandom);
    return t;
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic send(wtme_pkg::in_item_t t, bit typed, wtme_pkg::out_item_t typed_exp);
    wtme_pkg::out_item_t pred;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    do @(posedge clk); while (!in_ch.ready);
    pred = match_descriptor(t);
    pending_desc.push_back(typed ? typed_exp : pred);
  endtask

  initial begin
    wtme_pkg::out_item_t none;
    none = '0;
    errors = 0;
    calm = 0;
    stim_done = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    add_row(make_item(wtme_pkg::OP_PROBE, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1,
            wtme_pkg::ST_PROBE_MISS);
    add_row(make_item(wtme_pkg::OP_LOOKUP, 16'hFFFF, 1, 0, 1, 1, 0, 0, 0, 0, 0), 1'b1,
            wtme_pkg::ST_LOOKUP_MISS);
    add_row(make_item(wtme_pkg::OP_ARRIVE, 16'hFFFF, 0, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF),
            1'b1, wtme_pkg::ST_QUEUED);
    add_row(make_item(wtme_pkg::OP_PROBE, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1,
            wtme_pkg::ST_PROBE_HIT);
    add_row(make_item(wtme_pkg::OP_LOOKUP, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(wtme_pkg::OP_LOOKUP, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 0, 0));
    // Silent receives: positive, negative and zero offsets leave the arrival queued.
    add_row(make_item(wtme_pkg::OP_POST, 16'hFFFF, 0, 32'hFFFF_FFFF, 0, 1, 32'h7FFF_FFFF,
                      32'h10, 64'h1000, 32'hA, 16'h1));
    add_row(make_item(wtme_pkg::OP_POST, 0, 1, 0, 1, 1, 32'h8000_0000, 32'h20, 64'h2000,
                      32'hB, 16'h2));
    add_row(make_item(wtme_pkg::OP_POST, 0, 1, 7, 0, 1, 32'd0, 32'h30, 64'h3000, 32'hC,
                      16'h3));
    // Non-silent receive with wildcards removes the arrival.
    add_row(make_item(wtme_pkg::OP_POST, 0, 1, 0, 1, 0, 32'd5, 32'h40, 64'h4000, 32'hD,
                      16'h4));
    add_row(make_item(wtme_pkg::OP_PROBE, 16'hFFFF, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
    // Silent posted receive met by an arrival: receive leaves, arrival is queued.
    add_row(make_item(wtme_pkg::OP_POST, 5, 0, 9, 0, 1, 32'd64, 32'h50, 64'h5000, 32'hE,
                      16'h5));
    add_row(make_item(wtme_pkg::OP_ARRIVE, 5, 0, 9, 0, 0, 0, 32'h60, 64'hFFFF_FFFF_FFFF_FFF0,
                      32'hF, 16'h6));
    add_row(make_item(wtme_pkg::OP_ARRIVE, 0, 1, 0, 1, 0, 0, 32'h70, 64'h7000, 32'h1,
                      16'h7));
    add_row(make_item(wtme_pkg::OP_LOOKUP, 0, 0, 9, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(wtme_pkg::OP_LOOKUP, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    add_row(make_item(wtme_pkg::OP_POST, 5, 0, 9, 0, 0, 0, 32'h80, 64'h8000, 32'h2, 16'h8));
    add_row(make_item(wtme_pkg::OP_POST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(wtme_pkg::OP_ARRIVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    foreach (directed_rows[i]) send(directed_rows[i].item, directed_rows[i].typed,
                                    directed_rows[i].exp);

    for (int unsigned n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        while (pending_desc.size() != 0) @(posedge clk);
      end
      if (n == NUM_RANDOM - CALM_TAIL) calm = 1;
      send(random_item((n / 150) % 3), 1'b0, none);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    wtme_pkg::out_item_t got;
    wtme_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_desc.size() == 0) begin
        report("unexpected result status", 64'(got.status), 64'(0));
      end else begin
        want = pending_desc.pop_front();
        if (got.status != want.status)
          report("status", 64'(got.status), 64'(want.status));
        if (got.read_src_addr != want.read_src_addr)
          report("read_src_addr", got.read_src_addr, want.read_src_addr);
        if (got.remote_key != want.remote_key)
          report("remote_key", 64'(got.remote_key), 64'(want.remote_key));
        if (got.read_dst_addr != want.read_dst_addr)
          report("read_dst_addr", got.read_dst_addr, want.read_dst_addr);
        if (got.read_length != want.read_length)
          report("read_length", 64'(got.read_length), 64'(want.read_length));
        if (got.local_key != want.local_key)
          report("local_key", 64'(got.local_key), 64'(want.local_key));
        if (got.remote_handle != want.remote_handle)
          report("remote_handle", 64'(got.remote_handle), 64'(want.remote_handle));
        if (got.local_handle != want.local_handle)
          report("local_handle", 64'(got.local_handle), 64'(want.local_handle));
        if (got.found_source != want.found_source)
          report("found_source", 64'(got.found_source), 64'(want.found_source));
        if (got.found_any_source != want.found_any_source)
          report("found_any_source", 64'(got.found_any_source),
                 64'(want.found_any_source));
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_desc.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
